// ===== rtl/core/bounded_deque_with_match_delete_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bounded deque
// Concurrent checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_MATCH_DELETE_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_MATCH_DELETE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define BDQ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define BDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BDQ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define BDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/core/bdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int ACTION_W      = 3;
   localparam int STATUS_W      = 2;
   localparam int COUNT_OUT_W   = 5;

   localparam logic [ACTION_W-1:0] ACT_ADD_FRONT    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD_BACK     = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE_FRONT = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_REMOVE_BACK  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_REMOVE_MATCH = 3'd4;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_EMPTY   = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_NOMATCH = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_POP_FRONT,
      S_POP_BACK,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_END_RD,
      S_FRONT_DAT,
      S_BACK_DAT,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      ADDR_FRONT,
      ADDR_BACK,
      ADDR_IDX,
      ADDR_IDX_NEXT,
      ADDR_TAIL_NEXT,
      ADDR_HEAD_DEC
   } addr_sel_type;

   typedef struct packed {
      logic         load_req;
      addr_sel_type addr_sel;
      logic         wr_en;
      logic         wr_from_ram;
      logic         head_dec;
      logic         head_inc;
      logic         count_inc;
      logic         count_dec;
      logic         idx_inc;
      logic         cap_removed;
      logic         cap_front;
      logic         cap_back;
      logic         clr_ends;
      logic         set_status;
      status_type   status;
      logic         load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                empty;
      logic                full;
      logic                hit;
      logic                scan_last;
      logic                shift_more;
   } sts_type;

endpackage

// ===== rtl/core/bdq_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_req_if
// Request channel: action and value with valid/ready.
// ----------------------------------------------------------------------------
interface bdq_req_if;
   import bdq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic signed [DATA_W-1:0]   value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

// ===== rtl/core/bdq_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_rsp_if
// Response channel: status, removed value, count and end values.
// ----------------------------------------------------------------------------
interface bdq_rsp_if;
   import bdq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic signed [DATA_W-1:0]   removed_value;
   logic [COUNT_OUT_W-1:0]     entry_count;
   logic signed [DATA_W-1:0]   front_value;
   logic signed [DATA_W-1:0]   back_value;

   modport source (output valid, output status, output removed_value,
                   output entry_count, output front_value, output back_value,
                   input ready);
   modport sink   (input valid, input status, input removed_value,
                   input entry_count, input front_value, input back_value,
                   output ready);
endinterface

// ===== rtl/core/bdq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/bdq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_dp
// Datapath: circular store in RAM, head/count pointers, scan index,
// working result registers and the response output register.
// ----------------------------------------------------------------------------
module bdq_dp #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bdq_pkg::cmd_type                      cmd,
   output bdq_pkg::sts_type                      sts,
   input  logic [bdq_pkg::ACTION_W-1:0]          req_action,
   input  logic signed [bdq_pkg::DATA_W-1:0]     req_value,
   output logic [bdq_pkg::STATUS_W-1:0]          rsp_status,
   output logic signed [bdq_pkg::DATA_W-1:0]     rsp_removed_value,
   output logic [bdq_pkg::COUNT_OUT_W-1:0]       rsp_entry_count,
   output logic signed [bdq_pkg::DATA_W-1:0]     rsp_front_value,
   output logic signed [bdq_pkg::DATA_W-1:0]     rsp_back_value
);
   import bdq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 2;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

   logic [AW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [ACTION_W-1:0] action_ff, action_in;
   logic [DATA_W-1:0]   value_ff, value_in;
   status_type          status_ff, status_in;
   logic [DATA_W-1:0]   removed_ff, removed_in;
   logic [DATA_W-1:0]   front_ff, front_in;
   logic [DATA_W-1:0]   back_ff, back_in;

   status_type              out_status_ff, out_status_in;
   logic [DATA_W-1:0]       out_removed_ff, out_removed_in;
   logic [COUNT_OUT_W-1:0]  out_count_ff, out_count_in;
   logic [DATA_W-1:0]       out_front_ff, out_front_in;
   logic [DATA_W-1:0]       out_back_ff, out_back_in;

   logic [AW-1:0]     head_prev, head_next, addr;
   logic [CW-1:0]     offset;
   logic [SW-1:0]     sum, sum_wrap;
   logic [DATA_W-1:0] rd_data, wr_data;

   // map a logical position to a physical slot of the ring
   always_comb begin
      head_prev = (head_ff == '0) ? LAST_C : head_ff - 1'b1;
      head_next = (head_ff == LAST_C) ? '0 : head_ff + 1'b1;
      case (cmd.addr_sel)
         ADDR_FRONT:     offset = '0;
         ADDR_BACK:      offset = count_ff - 1'b1;
         ADDR_IDX:       offset = idx_ff;
         ADDR_IDX_NEXT:  offset = idx_ff + 1'b1;
         ADDR_TAIL_NEXT: offset = count_ff;
         default:        offset = '0;
      endcase
      sum      = SW'(head_ff) + SW'(offset);
      sum_wrap = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
      addr     = (cmd.addr_sel == ADDR_HEAD_DEC) ? head_prev : sum_wrap[AW-1:0];
   end

   assign wr_data = cmd.wr_from_ram ? rd_data : value_ff;

   bdq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (addr),
      .wr_data (wr_data),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   always_comb begin
      head_in = head_ff;
      if (cmd.head_dec) begin
         head_in = head_prev;
      end else if (cmd.head_inc) begin
         head_in = head_next;
      end

      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.count_dec) begin
         count_in = count_ff - 1'b1;
      end

      idx_in = idx_ff;
      if (cmd.load_req) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end

      action_in = cmd.load_req ? req_action : action_ff;
      value_in  = cmd.load_req ? req_value  : value_ff;

      status_in = status_ff;
      if (cmd.load_req) begin
         status_in = STAT_OK;
      end else if (cmd.set_status) begin
         status_in = cmd.status;
      end

      removed_in = removed_ff;
      if (cmd.load_req) begin
         removed_in = '0;
      end else if (cmd.cap_removed) begin
         removed_in = rd_data;
      end

      front_in = front_ff;
      back_in  = back_ff;
      if (cmd.clr_ends) begin
         front_in = '0;
         back_in  = '0;
      end
      if (cmd.cap_front) begin
         front_in = rd_data;
      end
      if (cmd.cap_back) begin
         back_in = rd_data;
      end

      out_status_in  = out_status_ff;
      out_removed_in = out_removed_ff;
      out_count_in   = out_count_ff;
      out_front_in   = out_front_ff;
      out_back_in    = out_back_ff;
      if (cmd.load_rsp) begin
         out_status_in  = status_ff;
         out_removed_in = removed_ff;
         out_count_in   = COUNT_OUT_W'(count_ff);
         out_front_in   = front_ff;
         out_back_in    = back_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      action_ff      <= action_in;
      value_ff       <= value_in;
      status_ff      <= status_in;
      removed_ff     <= removed_in;
      front_ff       <= front_in;
      back_ff        <= back_in;
      out_status_ff  <= out_status_in;
      out_removed_ff <= out_removed_in;
      out_count_ff   <= out_count_in;
      out_front_ff   <= out_front_in;
      out_back_ff    <= out_back_in;
   end

   always_comb begin
      sts.action     = action_ff;
      sts.empty      = (count_ff == '0);
      sts.full       = (count_ff == DEPTH_C);
      sts.hit        = (rd_data == value_ff);
      sts.scan_last  = ((idx_ff + 1'b1) == count_ff);
      sts.shift_more = ((CW+1)'(idx_ff) + (CW+1)'(2)) < (CW+1)'(count_ff);
   end

   assign rsp_status        = out_status_ff;
   assign rsp_removed_value = out_removed_ff;
   assign rsp_entry_count   = out_count_ff;
   assign rsp_front_value   = out_front_ff;
   assign rsp_back_value    = out_back_ff;
endmodule

// ===== rtl/core/bdq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ctrl
// Controller: sequences one request through the datapath and owns the
// request/response handshakes.
// ----------------------------------------------------------------------------
module bdq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  bdq_pkg::sts_type sts,
   output bdq_pkg::cmd_type cmd
);
   import bdq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.action)
               ACT_REMOVE_FRONT: state_in = sts.empty ? S_END_RD : S_POP_FRONT;
               ACT_REMOVE_BACK:  state_in = sts.empty ? S_END_RD : S_POP_BACK;
               ACT_REMOVE_MATCH: state_in = sts.empty ? S_END_RD : S_SCAN_RD;
               default:          state_in = S_END_RD;
            endcase
         end
         S_POP_FRONT: state_in = S_END_RD;
         S_POP_BACK:  state_in = S_END_RD;
         S_SCAN_RD:   state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (sts.hit && !sts.scan_last) begin
               state_in = S_SHIFT_RD;
            end else if (sts.hit || sts.scan_last) begin
               state_in = S_END_RD;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: state_in = sts.shift_more ? S_SHIFT_RD : S_END_RD;
         S_END_RD:   state_in = sts.empty ? S_DONE : S_FRONT_DAT;
         S_FRONT_DAT: state_in = S_BACK_DAT;
         S_BACK_DAT:  state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.addr_sel = ADDR_FRONT;
      cmd.status   = STAT_OK;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         S_DECODE: begin
            case (sts.action)
               ACT_ADD_FRONT: begin
                  if (sts.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STAT_FULL;
                  end else begin
                     cmd.addr_sel  = ADDR_HEAD_DEC;
                     cmd.wr_en     = 1'b1;
                     cmd.head_dec  = 1'b1;
                     cmd.count_inc = 1'b1;
                  end
               end
               ACT_ADD_BACK: begin
                  if (sts.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STAT_FULL;
                  end else begin
                     cmd.addr_sel  = ADDR_TAIL_NEXT;
                     cmd.wr_en     = 1'b1;
                     cmd.count_inc = 1'b1;
                  end
               end
               ACT_REMOVE_FRONT, ACT_REMOVE_BACK, ACT_REMOVE_MATCH: begin
                  cmd.addr_sel = (sts.action == ACT_REMOVE_BACK) ? ADDR_BACK
                                                                 : ADDR_FRONT;
                  if (sts.empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STAT_EMPTY;
                  end
               end
               default: begin
                  cmd.addr_sel = ADDR_FRONT;
               end
            endcase
         end
         S_POP_FRONT: begin
            cmd.cap_removed = 1'b1;
            cmd.head_inc    = 1'b1;
            cmd.count_dec   = 1'b1;
         end
         S_POP_BACK: begin
            cmd.cap_removed = 1'b1;
            cmd.count_dec   = 1'b1;
         end
         S_SCAN_RD: begin
            cmd.addr_sel = ADDR_IDX;
         end
         S_SCAN_CHK: begin
            if (sts.hit) begin
               cmd.cap_removed = 1'b1;
               cmd.count_dec   = sts.scan_last;
            end else if (sts.scan_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = STAT_NOMATCH;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_SHIFT_RD: begin
            cmd.addr_sel = ADDR_IDX_NEXT;
         end
         S_SHIFT_WR: begin
            // move the entry just read down into the gap
            cmd.addr_sel    = ADDR_IDX;
            cmd.wr_en       = 1'b1;
            cmd.wr_from_ram = 1'b1;
            cmd.idx_inc     = 1'b1;
            cmd.count_dec   = !sts.shift_more;
         end
         S_END_RD: begin
            cmd.addr_sel = ADDR_FRONT;
            cmd.clr_ends = sts.empty;
         end
         S_FRONT_DAT: begin
            cmd.addr_sel  = ADDR_BACK;
            cmd.cap_front = 1'b1;
         end
         S_BACK_DAT: begin
            cmd.cap_back = 1'b1;
         end
         S_DONE: begin
            cmd.load_rsp = out_free;
         end
         default: begin
            cmd.addr_sel = ADDR_FRONT;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == S_DONE && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== rtl/core/bounded_deque_with_match_delete.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_match_delete
// Bounded double-ended queue of signed words with delete-by-value.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one request (action, value) per valid/ready handshake;
//   rsp_ch returns exactly one response per request: status, removed value,
//   entry count and the front and back values after the operation.
//   Requests are handled one at a time. Entries live in a single-port-read
//   ring buffer RAM, so accesses take turns on that one read port.
//   After decode, a pop captures the removed entry; every request then reads
//   the front and back values into the working registers, or clears both
//   to zero when the deque is left empty. A match delete reads and checks
//   entries from the front until a hit or the back, then reads and writes
//   each entry behind the hit to shift it down and close the gap.
//   req_ch.ready is high only while the block is idle.
//   The response sits in an output register; a new request is taken while
//   it waits, and a stalled receiver holds the finished next response in
//   the working registers until the output register frees up.
//   Reset (synchronous) empties the deque; the RAM is not cleared, since
//   slots are only read below the fill count.
// ----------------------------------------------------------------------------
`include "bounded_deque_with_match_delete_defines.svh"

module bounded_deque_with_match_delete #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   bdq_req_if.sink   req_ch,
   bdq_rsp_if.source rsp_ch
);
   import bdq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bdq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_action        (req_ch.action),
      .req_value         (req_ch.value),
      .rsp_status        (rsp_ch.status),
      .rsp_removed_value (rsp_ch.removed_value),
      .rsp_entry_count   (rsp_ch.entry_count),
      .rsp_front_value   (rsp_ch.front_value),
      .rsp_back_value    (rsp_ch.back_value)
   );

   `BDQ_ASSERT_NEXT(a_busy_after_req, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready, "request accepted while busy")
   `BDQ_ASSERT_IMPL(a_full_count, clock, reset, rsp_ch.valid && rsp_ch.status == STAT_FULL, rsp_ch.entry_count == COUNT_OUT_W'(DEPTH), "full status with deque not full")
   `BDQ_ASSERT_IMPL(a_empty_clean, clock, reset, rsp_ch.valid && rsp_ch.status == STAT_EMPTY, rsp_ch.entry_count == '0 && rsp_ch.removed_value == '0, "empty status with data")
   `BDQ_ASSERT_IMPL(a_nomatch_clean, clock, reset, rsp_ch.valid && rsp_ch.status == STAT_NOMATCH, rsp_ch.removed_value == '0, "failed match reports a removed value")
endmodule

// ===== tb/sv/tb_bounded_deque_with_match_delete.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_match_delete
// Drives deque requests (insert/remove at both ends, delete by value) through
// the request channel and checks every response, field by field, against a
// local deque model. Phases vary idling on the sender and receiver sides.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_match_delete;
   import bdq_pkg::*;

   localparam int DEPTH        = DEPTH_DEFAULT;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [ACTION_W-1:0]      action;
      logic signed [DATA_W-1:0] value;
   } deque_req_type;

   typedef struct packed {
      status_type               status;
      logic signed [DATA_W-1:0] removed_value;
      logic [COUNT_OUT_W-1:0]   entry_count;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] back_value;
   } deque_rsp_type;

   typedef struct packed {
      logic [DEPTH-1:0][DATA_W-1:0] slot;
      logic [6:0]                   fill;
   } deque_state_type;

   logic clock;
   logic reset;

   bdq_req_if req_ch ();
   bdq_rsp_if rsp_ch ();

   bounded_deque_with_match_delete u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   deque_req_type   queued_requests[$];
   deque_rsp_type   pending_responses[$];
   deque_state_type stim_deque;
   deque_state_type model_deque;
   idle_mode_type   idle_mode;
   logic            req_fired;
   logic            stim_filling;
   deque_req_type   drive_item;
   deque_req_type   seen_req;
   deque_rsp_type   oldest_rsp;
   deque_rsp_type   predicted_rsp;
   int              mismatch_count;
   int              cycle_count;
   int              requests_sent;
   int              responses_seen;
   int              full_refusals;
   int              empty_refusals;
   int              nomatch_count;
   int              match_removals;

   always #6 clock = ~clock;

   // Apply one request to a deque state and return the response it produces.
   function automatic deque_rsp_type apply_deque_op(inout deque_state_type st,
                                                    input deque_req_type rq);
      deque_rsp_type r;
      int            hit;
      int            i;
      r        = '0;
      r.status = STAT_OK;
      hit      = -1;
      case (rq.action)
         ACT_ADD_FRONT, ACT_ADD_BACK: begin
            if (st.fill >= DEPTH) begin
               r.status = STAT_FULL;
            end else if (rq.action == ACT_ADD_FRONT) begin
               for (i = DEPTH - 1; i > 0; i--) st.slot[i] = st.slot[i-1];
               st.slot[0] = rq.value;
               st.fill++;
            end else begin
               st.slot[st.fill] = rq.value;
               st.fill++;
            end
         end
         ACT_REMOVE_FRONT: begin
            if (st.fill == 0) r.status = STAT_EMPTY;
            else hit = 0;
         end
         ACT_REMOVE_BACK: begin
            if (st.fill == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.removed_value = st.slot[st.fill-1];
               st.fill--;
            end
         end
         ACT_REMOVE_MATCH: begin
            if (st.fill == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               for (i = 0; i < st.fill; i++)
                  if (hit < 0 && st.slot[i] == rq.value) hit = i;
               if (hit < 0) r.status = STAT_NOMATCH;
            end
         end
         default: ;
      endcase
      // close the gap left by a front or match removal
      if (hit >= 0) begin
         r.removed_value = st.slot[hit];
         for (i = hit; i < DEPTH - 1; i++) st.slot[i] = st.slot[i+1];
         st.fill--;
      end
      r.entry_count = st.fill[COUNT_OUT_W-1:0];
      if (st.fill != 0) begin
         r.front_value = st.slot[0];
         r.back_value  = st.slot[st.fill-1];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH response %0d: %s", $realtime, responses_seen, msg);
      mismatch_count++;
   endtask

   task automatic queue_request(input logic [ACTION_W-1:0] action,
                                input logic signed [DATA_W-1:0] value);
      deque_req_type rq;
      rq.action = action;
      rq.value  = value;
      void'(apply_deque_op(stim_deque, rq));
      queued_requests.push_back(rq);
   endtask

   // Many small values so duplicates and matches occur, plus extremes and random words.
   function automatic logic signed [DATA_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(99);
      if (sel < 40) return $urandom_range(8) - 4;
      if (sel < 50) begin
         case ($urandom_range(3))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 0;
            default: return -1;
         endcase
      end
      return $urandom;
   endfunction

   // Fill to full, then drain to empty, in waves; a few requests are noise.
   task automatic queue_random(input int n);
      int                  sel;
      logic [ACTION_W-1:0] act;
      logic signed [DATA_W-1:0] val;
      repeat (n) begin
         if (stim_deque.fill == DEPTH) stim_filling = 1'b0;
         if (stim_deque.fill == 0) stim_filling = 1'b1;
         sel = $urandom_range(99);
         if (sel < 3) begin
            act = ACTION_W'($urandom_range(7, 5));
         end else if (sel < 8) begin
            act = ACTION_W'($urandom_range(4));
         end else if ($urandom_range(99) < (stim_filling ? 70 : 30)) begin
            act = $urandom_range(1) ? ACT_ADD_BACK : ACT_ADD_FRONT;
         end else begin
            sel = $urandom_range(99);
            act = (sel < 30) ? ACT_REMOVE_FRONT : (sel < 60) ? ACT_REMOVE_BACK :
                  ACT_REMOVE_MATCH;
         end
         if (act == ACT_REMOVE_MATCH && stim_deque.fill != 0 && $urandom_range(99) < 70)
            val = stim_deque.slot[$urandom_range(stim_deque.fill - 1)];
         else
            val = pick_value();
         queue_request(act, val);
      end
   endtask

   task automatic wait_requests_sent();
      while (queued_requests.size() != 0) @(posedge clock);
   endtask

   // Sender: hold a request until it is taken, then load the next or idle.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fired) begin
         if (queued_requests.size() != 0 &&
             !(idle_mode == IDLE_SEND && $urandom_range(99) < 77) &&
             !(idle_mode == IDLE_BOTH && $urandom_range(99) < 6)) begin
            drive_item    = queued_requests.pop_front();
            req_ch.valid  <= 1'b1;
            req_ch.action <= drive_item.action;
            req_ch.value  <= drive_item.value;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver stalls
   always @(negedge clock) begin
      rsp_ch.ready <= !((idle_mode == IDLE_RECV && $urandom_range(99) < 77) ||
                        (idle_mode == IDLE_BOTH && $urandom_range(99) < 6));
   end

   always @(posedge clock) begin
      req_fired <= req_ch.valid && req_ch.ready;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_responses.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               oldest_rsp = pending_responses.pop_front();
               if (rsp_ch.status !== oldest_rsp.status)
                  report_mismatch($sformatf("status got %0d expected %0d",
                                            rsp_ch.status, oldest_rsp.status));
               if (rsp_ch.removed_value !== oldest_rsp.removed_value)
                  report_mismatch($sformatf("removed_value got %0d expected %0d",
                                            rsp_ch.removed_value, oldest_rsp.removed_value));
               if (rsp_ch.entry_count !== oldest_rsp.entry_count)
                  report_mismatch($sformatf("entry_count got %0d expected %0d",
                                            rsp_ch.entry_count, oldest_rsp.entry_count));
               if (rsp_ch.front_value !== oldest_rsp.front_value)
                  report_mismatch($sformatf("front_value got %0d expected %0d",
                                            rsp_ch.front_value, oldest_rsp.front_value));
               if (rsp_ch.back_value !== oldest_rsp.back_value)
                  report_mismatch($sformatf("back_value got %0d expected %0d",
                                            rsp_ch.back_value, oldest_rsp.back_value));
            end
            responses_seen++;
         end
         if (req_ch.valid && req_ch.ready) begin
            seen_req.action = req_ch.action;
            seen_req.value  = req_ch.value;
            predicted_rsp   = apply_deque_op(model_deque, seen_req);
            pending_responses.push_back(predicted_rsp);
            requests_sent++;
            case (predicted_rsp.status)
               STAT_FULL:    full_refusals++;
               STAT_EMPTY:   empty_refusals++;
               STAT_NOMATCH: nomatch_count++;
               default: if (seen_req.action == ACT_REMOVE_MATCH) match_removals++;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_responses.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.action  = ACT_ADD_FRONT;
      req_ch.value   = '0;
      rsp_ch.ready   = 1'b0;
      req_fired      = 1'b0;
      stim_filling   = 1'b1;
      stim_deque     = '0;
      model_deque    = '0;
      idle_mode      = IDLE_NONE;
      mismatch_count = 0;
      cycle_count    = 0;
      requests_sent  = 0;
      responses_seen = 0;
      full_refusals  = 0;
      empty_refusals = 0;
      nomatch_count  = 0;
      match_removals = 0;

      // removals on an empty store, then unused action codes
      queue_request(ACT_REMOVE_FRONT, 1);
      queue_request(ACT_REMOVE_BACK, 2);
      queue_request(ACT_REMOVE_MATCH, 3);
      queue_request(3'd5, -5);
      queue_request(3'd6, 6);
      queue_request(3'd7, 32'sh7fffffff);
      // extremes at both ends: [-1, max, min, 0]
      queue_request(ACT_ADD_FRONT, 32'sh7fffffff);
      queue_request(ACT_ADD_BACK, 32'sh80000000);
      queue_request(ACT_ADD_FRONT, -1);
      queue_request(ACT_ADD_BACK, 0);
      // match at the front, at the back, then a miss
      queue_request(ACT_REMOVE_MATCH, -1);
      queue_request(ACT_REMOVE_MATCH, 0);
      queue_request(ACT_REMOVE_MATCH, 12345);
      // drain to empty; the last removal leaves both ends zero
      queue_request(ACT_REMOVE_FRONT, 0);
      queue_request(ACT_REMOVE_BACK, 0);
      // duplicates: only the first match goes
      queue_request(ACT_ADD_BACK, 7);
      queue_request(ACT_ADD_BACK, 7);
      queue_request(ACT_ADD_FRONT, 3);
      queue_request(ACT_ADD_BACK, 9);
      queue_request(ACT_REMOVE_MATCH, 7);
      queue_request(ACT_REMOVE_MATCH, 7);
      queue_request(ACT_REMOVE_MATCH, 7);
      queue_request(ACT_REMOVE_MATCH, 9);
      queue_request(ACT_REMOVE_MATCH, 3);

      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      queue_random(75);
      wait_requests_sent();
      idle_mode = IDLE_SEND;
      queue_random(100);
      wait_requests_sent();
      idle_mode = IDLE_RECV;
      queue_random(100);
      wait_requests_sent();
      idle_mode = IDLE_BOTH;
      queue_random(100);
      wait_requests_sent();

      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests and %0d responses over four idling phases",
               requests_sent, responses_seen);
      $display("Refusals: %0d full, %0d empty, %0d no match; %0d deletes by value",
               full_refusals, empty_refusals, nomatch_count, match_removals);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bdq_pkg.sv
rtl/core/bdq_req_if.sv
rtl/core/bdq_rsp_if.sv
rtl/core/bdq_ram.sv
rtl/core/bdq_dp.sv
rtl/core/bdq_ctrl.sv
rtl/core/bounded_deque_with_match_delete.sv
tb/sv/tb_bounded_deque_with_match_delete.sv
